>>> rtl/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg: shared types and constants of the median window filter
// Register map, config bundle and per-item control flags used across modules.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int KERNEL_SIZE_DEF = 3;
  localparam int MAX_WIDTH_DEF   = 1024;

  localparam int PIXEL_BITS  = 8;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // effective frame geometry plus frame restart strobe
  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic                   restart;
  } cfg_t;

  typedef struct packed {
    logic border;
    logic last;
  } item_ctl_t;

endpackage

>>> rtl/mwf_ram.sv
// ----------------------------------------------------------------------------
// mwf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mwf_front.sv
// ----------------------------------------------------------------------------
// mwf_front: position tracking, line buffers and window gather
// Counts input and output positions, keeps 2*PAD rows of history and
// hands each emitting transaction's full window to the queue.
// ----------------------------------------------------------------------------
module mwf_front #(
  parameter int KERNEL_SIZE = mwf_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = mwf_pkg::MAX_WIDTH_DEF,
  localparam int PAD        = KERNEL_SIZE / 2,
  localparam int WIN        = 2 * PAD + 1,
  localparam int TAPS       = WIN * WIN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mwf_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  input  logic                                in_kind,
  input  logic [mwf_pkg::PIXEL_BITS-1:0]      in_pixel,
  output logic                                out_valid,
  output logic [TAPS*mwf_pkg::PIXEL_BITS-1:0] out_taps,
  output logic [mwf_pkg::PIXEL_BITS-1:0]      out_center,
  output mwf_pkg::item_ctl_t                  out_ctl
);

  localparam int PB    = mwf_pkg::PIXEL_BITS;
  localparam int LANES = 2 * PAD;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LW    = $clog2(PAD * MAX_WIDTH + PAD + 1);
  localparam int HB    = mwf_pkg::HEIGHT_BITS;

  // input side position
  logic [CW-1:0] in_col;
  logic [LW-1:0] t_cnt;
  logic          primed;
  // output side position
  logic [CW-1:0] out_x;
  logic [HB-1:0] out_y;

  logic [31:0]   w32, h32;
  logic [LW-1:0] lag;
  logic          emit, col_last, x_last, is_last, is_border;

  always_comb begin
    w32       = 32'(cfg.width);
    h32       = 32'(cfg.height);
    lag       = LW'(PAD * w32 + PAD);
    emit      = primed || (t_cnt == lag);
    col_last  = (32'(in_col) + 32'd1 == w32);
    x_last    = (32'(out_x) + 32'd1 == w32);
    is_last   = x_last && (32'(out_y) + 32'd1 == h32);
    is_border = (32'(out_x) < PAD) || (32'(out_x) + PAD >= w32) ||
                (32'(out_y) < PAD) || (32'(out_y) + PAD >= h32);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      in_col <= '0;
      t_cnt  <= '0;
      primed <= 1'b0;
      out_x  <= '0;
      out_y  <= '0;
    end else if (in_valid) begin
      in_col <= col_last ? '0 : in_col + 1'b1;
      if (!primed) begin
        t_cnt <= t_cnt + 1'b1;
      end
      if (emit) begin
        primed <= 1'b1;
        if (is_last) begin
          // frame done: start over
          in_col <= '0;
          t_cnt  <= '0;
          primed <= 1'b0;
          out_x  <= '0;
          out_y  <= '0;
        end else if (x_last) begin
          out_x <= '0;
          out_y <= out_y + 1'b1;
        end else begin
          out_x <= out_x + 1'b1;
        end
      end
    end
  end

  // stage 1: line buffer data returns
  logic               s1_valid, s1_emit;
  logic [CW-1:0]      s1_col;
  logic [PB-1:0]      s1_pix;
  mwf_pkg::item_ctl_t s1_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_col     <= in_col;
    s1_pix     <= in_kind ? '0 : in_pixel;
    s1_emit    <= in_valid && emit;
    s1_ctl.border <= is_border;
    s1_ctl.last   <= is_last;
  end

  logic [LANES*PB-1:0] ram_rdata, lanes_rd, lanes_wr;
  logic [LANES*PB-1:0] lw_data;
  logic [CW-1:0]       lw_addr;
  logic                lw_valid;

  mwf_ram #(
    .WIDTH (LANES * PB),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (lanes_wr),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  // write-to-read bypass for back to back hits on one column
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (s1_valid) begin
      lw_valid <= 1'b1;
    end
    if (s1_valid) begin
      lw_addr <= s1_col;
      lw_data <= lanes_wr;
    end
  end

  logic [PB-1:0] col_vec [WIN];
  logic [PB-1:0] win      [WIN][WIN];
  logic [PB-1:0] win_next [WIN][WIN];

  always_comb begin
    lanes_rd = (lw_valid && lw_addr == s1_col) ? lw_data : ram_rdata;
    // lane j holds the pixel from j+1 rows ago
    lanes_wr = {lanes_rd[(LANES-1)*PB-1:0], s1_pix};
    for (int k = 0; k < LANES; k++) begin
      col_vec[k] = lanes_rd[(LANES-1-k)*PB +: PB];
    end
    col_vec[LANES] = s1_pix;
    for (int c = 0; c < WIN - 1; c++) begin
      win_next[c] = win[c+1];
    end
    win_next[WIN-1] = col_vec;
    for (int c = 0; c < WIN; c++) begin
      for (int k = 0; k < WIN; k++) begin
        out_taps[(c*WIN+k)*PB +: PB] = win_next[c][k];
      end
    end
    out_center = win_next[PAD][PAD];
    out_valid  = s1_valid && s1_emit;
    out_ctl    = s1_ctl;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win <= win_next;
    end
  end

`ifndef SYNTH
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.restart |=> (!primed && in_col == '0 && out_x == '0 && out_y == '0))
    else $error("frame restart did not clear position");
`endif

endmodule

>>> rtl/mwf_queue.sv
// ----------------------------------------------------------------------------
// mwf_queue: short FIFO between front and back
// Flip-flop storage, first-word-fall-through read, occupancy count out.
// ----------------------------------------------------------------------------
module mwf_queue #(
  parameter int WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [WIDTH-1:0]              wdata,
  input  logic                          pop,
  output logic [WIDTH-1:0]              rdata,
  output logic                          empty,
  output logic [mwf_pkg::QUEUE_CW-1:0]  count
);

  logic [WIDTH-1:0]             mem [mwf_pkg::QUEUE_DEPTH];
  logic [mwf_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == mwf_pkg::QUEUE_CW'(mwf_pkg::QUEUE_DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue underflow");
`endif

endmodule

>>> rtl/mwf_back.sv
// ----------------------------------------------------------------------------
// mwf_back: median select pipeline and output register
// Rank by pairwise compare, pick rank TAPS/2, mux border pixel, hold result.
// ----------------------------------------------------------------------------
module mwf_back #(
  parameter int KERNEL_SIZE = mwf_pkg::KERNEL_SIZE_DEF,
  localparam int PAD        = KERNEL_SIZE / 2,
  localparam int WIN        = 2 * PAD + 1,
  localparam int TAPS       = WIN * WIN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  logic [TAPS*mwf_pkg::PIXEL_BITS-1:0] q_taps,
  input  logic [mwf_pkg::PIXEL_BITS-1:0]      q_center,
  input  mwf_pkg::item_ctl_t                  q_ctl,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic [mwf_pkg::PIXEL_BITS-1:0]      pixel_out,
  output logic                                last_of_frame
);

  localparam int PB = mwf_pkg::PIXEL_BITS;
  localparam int RW = $clog2(TAPS + 1);

  logic en;
  logic va, vb, vc;

  logic [PB-1:0]      a_taps [TAPS];
  logic [TAPS-1:0]    a_lt   [TAPS];
  logic [PB-1:0]      a_center;
  mwf_pkg::item_ctl_t a_ctl;

  logic [PB-1:0]      b_taps [TAPS];
  logic [TAPS-1:0]    b_sel;
  logic [PB-1:0]      b_center;
  mwf_pkg::item_ctl_t b_ctl;

  logic [PB-1:0]      q_tap  [TAPS];
  logic [TAPS-1:0]    lt_d   [TAPS];
  logic [TAPS-1:0]    sel_d;
  logic [PB-1:0]      med;

  assign en    = !vc || pop;
  assign q_pop = en && q_valid;
  assign empty = !vc;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      q_tap[i] = q_taps[i*PB +: PB];
    end
    // j ranks below i: smaller, or equal and earlier
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        lt_d[i][j] = (q_tap[j] < q_tap[i]) || ((q_tap[j] == q_tap[i]) && (j < i));
      end
    end
    for (int i = 0; i < TAPS; i++) begin
      sel_d[i] = (RW'($countones(a_lt[i])) == RW'(TAPS / 2));
    end
    med = '0;
    for (int i = 0; i < TAPS; i++) begin
      med = med | (b_taps[i] & {PB{b_sel[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= q_valid;
      vb <= va;
      vc <= vb;
    end
    if (en) begin
      a_taps        <= q_tap;
      a_lt          <= lt_d;
      a_center      <= q_center;
      a_ctl         <= q_ctl;
      b_taps        <= a_taps;
      b_sel         <= sel_d;
      b_center      <= a_center;
      b_ctl         <= a_ctl;
      pixel_out     <= b_ctl.border ? b_center : med;
      last_of_frame <= b_ctl.last;
    end
  end

`ifndef SYNTH
  // border windows may hold stale line data, so only interior ones are checked
  a_one_median: assert property (@(posedge clk) disable iff (rst)
    (vb && !b_ctl.border) |-> $onehot(b_sel))
    else $error("median select not one-hot");
`endif

endmodule

>>> rtl/median_window_filter.sv
// ----------------------------------------------------------------------------
// median_window_filter: streaming K x K median filter, 8-bit grey pixels
// Raster in, raster out; border pixels pass through; last output flagged.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | push / full               | kind, pixel_in
//  result   | empty / pop               | pixel_out, last_of_frame
//  config   | psel penable pwrite pready| paddr, pwdata, prdata
//
//  One transaction per clock sustained in both directions while full is
//  low and pop is high; the line buffer RAM has one read and one write port,
//  used once per transaction. From input to result the data passes front
//  stage 1 (line buffer read), a queue entry and the back's a, b and output
//  registers. rst is synchronous, clears counters and pipeline valids and
//  sets both config registers to 512. A stalled result (pop low) freezes the
//  back end; the front keeps taking transactions until the 4-entry queue
//  would fill, then raises full.
//  Register map: 0x0 image_width (11 bit), 0x4 image_height (13 bit).
//  A write restarts the frame. Width 0 acts as 1, above MAX_WIDTH saturates;
//  height 0 acts as 1. After each frame send PAD*width + PAD drain
//  transactions (kind = 1) to flush the pending outputs.
// ----------------------------------------------------------------------------
module median_window_filter #(
  parameter int KERNEL_SIZE = mwf_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = mwf_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mwf_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [mwf_pkg::DATA_BITS-1:0]     pwdata,
  output logic [mwf_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  // input side
  input  logic                              push,
  output logic                              full,
  input  logic                              kind,
  input  logic [mwf_pkg::PIXEL_BITS-1:0]    pixel_in,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic [mwf_pkg::PIXEL_BITS-1:0]    pixel_out,
  output logic                              last_of_frame
);

  localparam int PB    = mwf_pkg::PIXEL_BITS;
  localparam int PAD   = KERNEL_SIZE / 2;
  localparam int WIN   = 2 * PAD + 1;
  localparam int TAPS  = WIN * WIN;
  localparam int CTLB  = $bits(mwf_pkg::item_ctl_t);
  localparam int QW    = TAPS * PB + PB + CTLB;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [mwf_pkg::WIDTH_BITS-1:0]  image_width;
  logic [mwf_pkg::HEIGHT_BITS-1:0] image_height;
  logic                            cfg_wr;
  mwf_pkg::cfg_t                   cfg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mwf_pkg::WIDTH_BITS'(512);
      image_height <= mwf_pkg::HEIGHT_BITS'(512);
    end else if (cfg_wr) begin
      // word select only; low address bits address bytes within a register
      unique case (paddr[2])
        mwf_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[mwf_pkg::WIDTH_BITS-1:0];
        mwf_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[mwf_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mwf_pkg::REG_IMAGE_WIDTH:  prdata = mwf_pkg::DATA_BITS'(image_width);
      mwf_pkg::REG_IMAGE_HEIGHT: prdata = mwf_pkg::DATA_BITS'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // effective geometry
  always_comb begin
    if (image_width == '0) begin
      cfg.width = mwf_pkg::WIDTH_BITS'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      cfg.width = mwf_pkg::WIDTH_BITS'(MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    cfg.height  = (image_height == '0) ? mwf_pkg::HEIGHT_BITS'(1) : image_height;
    cfg.restart = cfg_wr;
  end

  // --------------------------------------------------------------------------
  // Front: position tracking and window gather
  // --------------------------------------------------------------------------
  logic                  in_acc;
  logic                  f_valid;
  logic [TAPS*PB-1:0]    f_taps;
  logic [PB-1:0]         f_center;
  mwf_pkg::item_ctl_t    f_ctl;
  logic [mwf_pkg::QUEUE_CW-1:0] q_count;

  // count the transaction in front stage 1 against queue room
  assign full   = ({1'b0, q_count} + {{mwf_pkg::QUEUE_CW{1'b0}}, f_valid})
                  >= (mwf_pkg::QUEUE_CW+1)'(mwf_pkg::QUEUE_DEPTH);
  assign in_acc = push && !full;

  mwf_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_acc),
    .in_kind    (kind),
    .in_pixel   (pixel_in),
    .out_valid  (f_valid),
    .out_taps   (f_taps),
    .out_center (f_center),
    .out_ctl    (f_ctl)
  );

  // --------------------------------------------------------------------------
  // Queue between front and back
  // --------------------------------------------------------------------------
  logic [QW-1:0]      q_rdata;
  logic               q_empty, q_pop;
  logic [TAPS*PB-1:0] q_taps;
  logic [PB-1:0]      q_center;
  mwf_pkg::item_ctl_t q_ctl;

  mwf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata ({f_taps, f_center, f_ctl}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign {q_taps, q_center, q_ctl} = q_rdata;

  // --------------------------------------------------------------------------
  // Back: median select and result register
  // --------------------------------------------------------------------------
  mwf_back #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .q_taps        (q_taps),
    .q_center      (q_center),
    .q_ctl         (q_ctl),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame)
  );

endmodule
